// ----- src/cbc_pkg.sv -----
// Types and constants shared by the cartridge bank controller.
package cbc_pkg;

  // Controller type codes, as written to the controller type register.
  typedef enum logic [1:0] {
    CT_MBC1 = 2'd0,
    CT_MBC2 = 2'd1,
    CT_MBC3 = 2'd2,
    CT_MBC5 = 2'd3
  } ctrl_type_e;

  // Configuration register indexes.
  localparam logic [1:0] CfgCtrlType   = 2'd0;
  localparam logic [1:0] CfgRomBankCnt = 2'd1;
  localparam logic [1:0] CfgRamBankCnt = 2'd2;

  // Address regions, taken from write address bits 14:13.
  localparam logic [1:0] RegionRamEn   = 2'd0;
  localparam logic [1:0] RegionRomBank = 2'd1;
  localparam logic [1:0] RegionRamBank = 2'd2;
  localparam logic [1:0] RegionMode    = 2'd3;

  // Register widths.
  localparam int unsigned RomBankW = 9;
  localparam int unsigned RomCntW  = 10;
  localparam int unsigned RamBankW = 4;
  localparam int unsigned RamCntW  = 5;
  localparam int unsigned OffsetW  = 23;
  localparam int unsigned BankShift = 14;

  // The divider retires one dividend bit per step.
  localparam int unsigned DivSteps = RomBankW;
  localparam int unsigned IterW    = $clog2(DivSteps);

  // Low nibble that enables external RAM.
  localparam logic [3:0] RamEnKey = 4'hA;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  // Which bank register the divider result goes to.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_ROM,
    OP_RAM
  } wrap_op_e;

  typedef struct packed {
    logic [14:0] write_address;
    logic [7:0]  write_data;
  } in_t;

  typedef struct packed {
    logic [8:0]  rom_bank;
    logic [22:0] rom_base_offset;
    logic [3:0]  ram_bank;
    logic        rtc_selected;
    logic        ram_enabled;
    logic        ram_banking_mode;
  } out_t;

  // MBC1 never selects banks 0x00, 0x20, 0x40 or 0x60; it maps them up by one.
  function automatic logic [RomBankW-1:0] mbc1_fix(input logic [RomBankW-1:0] v);
    if (v == 9'h000 || v == 9'h020 || v == 9'h040 || v == 9'h060) begin
      mbc1_fix = v + 9'd1;
    end else begin
      mbc1_fix = v;
    end
  endfunction

endpackage

// ----- src/cartridge_bank_controller.sv -----
// Cartridge bank controller: bank registers of an MBC1/2/3/5 cartridge mapper.
// A write that loads a ROM or RAM bank number passes through the shared restoring divider
// (one dividend bit per cycle), which wraps the bank modulo its count, and is then committed
// and the result loaded; any other write goes straight to the commit. No new write is taken
// until the result has been committed to the output register, which waits while a stalled
// result beat is still held. Reset (rst_ni low, asynchronous) selects MBC1.
module cartridge_bank_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [9:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cbc_pkg::in_t       in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cbc_pkg::out_t      out_data_o
);
  import cbc_pkg::*;

  // Configuration registers.
  ctrl_type_e          ctrl_type_q;
  logic [RomCntW-1:0]  rom_cnt_q;
  logic [RamCntW-1:0]  ram_cnt_q;

  // Bank state.
  logic [RomBankW-1:0] rom_bank_q, rom_bank_d;
  logic [RamBankW-1:0] ram_bank_q, ram_bank_d;
  logic                rtc_sel_q, rtc_sel_d;
  logic                ram_en_q, ram_en_d;
  logic                ram_mode_q, ram_mode_d;

  // Sequencer and divider.
  state_e              state_q, state_d;
  wrap_op_e            op_q, dec_op;
  logic                fix_q, dec_fix;
  logic [RomBankW-1:0] dvd_q, dec_dvd;
  logic [RomCntW-1:0]  div_q, dec_div;
  logic [RomCntW-1:0]  rem_q, rem_d;
  logic [IterW-1:0]    iter_q;

  // Output register.
  logic                out_valid_q;
  out_t                out_q;

  logic                in_accept;
  logic                out_free;
  logic                div_step;
  logic                commit;

  // Cfg port never stalls; writes must arrive only while the block is idle (not enforced).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_type_q <= CT_MBC1;
      rom_cnt_q   <= 10'd2;
      ram_cnt_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgCtrlType:   ctrl_type_q <= ctrl_type_e'(cfg_data_i[1:0]);
        CfgRomBankCnt: rom_cnt_q   <= cfg_data_i;
        CfgRamBankCnt: ram_cnt_q   <= cfg_data_i[RamCntW-1:0];
        default: ;
      endcase
    end
  end

  assign in_accept = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;

  // Write decode. Registers that need no wrap are updated at acceptance; a bank number
  // that needs wrapping is handed to the divider together with its bank count.
  always_comb begin
    logic [1:0] region;
    logic [7:0] wdata;
    region     = in_data_i.write_address[14:13];
    wdata      = in_data_i.write_data;
    dec_op     = OP_NONE;
    dec_fix    = 1'b0;
    dec_dvd    = '0;
    dec_div    = rom_cnt_q;
    ram_en_d   = ram_en_q;
    rtc_sel_d  = rtc_sel_q;
    ram_mode_d = ram_mode_q;
    case (region)
      RegionRamEn: begin
        if (!(ctrl_type_q == CT_MBC2 && in_data_i.write_address[4]) && ram_cnt_q != '0) begin
          ram_en_d = (wdata[3:0] == RamEnKey);
        end
      end
      RegionRomBank: begin
        dec_op = OP_ROM;
        case (ctrl_type_q)
          // MBC1 keeps only bank bits 7:5 here; bit 8 is dropped.
          CT_MBC1: dec_dvd = mbc1_fix({1'b0, rom_bank_q[7:5], wdata[4:0]});
          CT_MBC2: dec_dvd = (wdata[3:0] == 4'd0) ? 9'd1 : {5'd0, wdata[3:0]};
          CT_MBC3: begin
            dec_dvd = {2'd0, wdata[6:0]};
            dec_fix = 1'b1;
          end
          CT_MBC5: begin
            if (!in_data_i.write_address[12]) begin
              dec_dvd = {rom_bank_q[8], wdata};
            end else begin
              dec_dvd = {wdata[0], rom_bank_q[7:0]};
            end
          end
          default: dec_op = OP_NONE;
        endcase
      end
      RegionRamBank: begin
        dec_div = {{(RomCntW-RamCntW){1'b0}}, ram_cnt_q};
        case (ctrl_type_q)
          CT_MBC1: begin
            if (!ram_mode_q) begin
              dec_op  = OP_ROM;
              dec_div = rom_cnt_q;
              dec_dvd = mbc1_fix({2'd0, wdata[1:0], rom_bank_q[4:0]});
            end else begin
              // With fewer than two RAM banks the wrap yields bank 0 by itself.
              dec_op  = OP_RAM;
              dec_dvd = {7'd0, wdata[1:0]};
            end
          end
          CT_MBC3: begin
            if (wdata > 8'd3) begin
              rtc_sel_d = 1'b1;
            end else begin
              rtc_sel_d = 1'b0;
              dec_op    = OP_RAM;
              dec_dvd   = {7'd0, wdata[1:0]};
            end
          end
          CT_MBC5: begin
            dec_op  = OP_RAM;
            dec_dvd = {5'd0, wdata[3:0]};
          end
          default: ;
        endcase
      end
      RegionMode: begin
        if (ctrl_type_q == CT_MBC1) begin
          ram_mode_d = wdata[0];
        end
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (dec_op == OP_NONE) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (iter_q == IterW'(DivSteps - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    div_step   = 1'b0;
    commit     = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_DIV:  div_step   = 1'b1;
      ST_DONE: commit     = out_free;
      default: ;
    endcase
  end

  // One restoring-division step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    logic [RomCntW:0] trial;
    trial = {rem_q, dvd_q[RomBankW-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = RomCntW'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[RomCntW-1:0];
    end
  end

  // Commit of the wrapped bank. A zero count gives bank 0; on MBC3 a wrapped ROM bank 0
  // becomes bank 1.
  always_comb begin
    logic [RomCntW-1:0] wrapped;
    wrapped    = (div_q == '0) ? '0 : rem_q;
    rom_bank_d = rom_bank_q;
    ram_bank_d = ram_bank_q;
    case (op_q)
      OP_ROM: begin
        if (fix_q && div_q != '0 && wrapped == '0) begin
          rom_bank_d = 9'd1;
        end else begin
          rom_bank_d = wrapped[RomBankW-1:0];
        end
      end
      OP_RAM: ram_bank_d = wrapped[RamBankW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_NONE;
      fix_q       <= 1'b0;
      iter_q      <= '0;
      rom_bank_q  <= 9'd1;
      ram_bank_q  <= '0;
      rtc_sel_q   <= 1'b0;
      ram_en_q    <= 1'b0;
      ram_mode_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        op_q       <= dec_op;
        fix_q      <= dec_fix;
        iter_q     <= '0;
        ram_en_q   <= ram_en_d;
        rtc_sel_q  <= rtc_sel_d;
        ram_mode_q <= ram_mode_d;
        // Leaving RAM banking mode on MBC1 drops the RAM bank.
        if (in_data_i.write_address[14:13] == RegionMode && ctrl_type_q == CT_MBC1 &&
            !in_data_i.write_data[0]) begin
          ram_bank_q <= '0;
        end
      end else if (div_step) begin
        iter_q <= iter_q + IterW'(1);
      end
      if (commit) begin
        rom_bank_q  <= rom_bank_d;
        ram_bank_q  <= ram_bank_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Divider datapath and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      dvd_q <= dec_dvd;
      div_q <= dec_div;
      rem_q <= '0;
    end else if (div_step) begin
      dvd_q <= {dvd_q[RomBankW-2:0], 1'b0};
      rem_q <= rem_d;
    end
    if (commit) begin
      out_q.rom_bank         <= rom_bank_d;
      out_q.rom_base_offset  <= {rom_bank_d, {BankShift{1'b0}}};
      out_q.ram_bank         <= ram_bank_d;
      out_q.rtc_selected     <= rtc_sel_q;
      out_q.ram_enabled      <= ram_en_q;
      out_q.ram_banking_mode <= ram_mode_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the cartridge bank controller with directed rows and random CPU writes.
`timescale 1ns / 100ps

module tb;
  import cbc_pkg::*;

  // The block has only three registers; index three selects nothing and must be ignored.
  localparam logic [1:0] CfgUnused = 2'd3;

  // Cycles with no accepted beat on any channel before the run is declared hung.
  localparam int unsigned IdleLimit = 2000;
  // Idle cycles left before a register write, so the block has surely returned to idle.
  localparam int unsigned SettleCycles = 4;
  // Cycles watched after the last result, longer than the slowest write.
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned RandPhases = 10;
  localparam int unsigned BeatsPerPhase = 48;

  typedef enum logic {
    ROW_REG,
    ROW_BEAT
  } row_kind_e;

  // One row of the directed part: either a register write or a CPU write beat.
  // A beat row may carry its expected bank state typed in; otherwise the predictor decides.
  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [14:0] addr;
    logic [9:0]  data;
    logic        typed;
    out_t        state;
  } row_t;

  localparam int unsigned NumRows = 38;

  localparam row_t PLAN [NumRows] = '{
    // Straight out of reset: MBC1, two ROM banks, no RAM.
    // The RAM enable write is dropped because there is no RAM.
    '{ROW_BEAT, '0, 15'h0000, 10'h00A, 1'b1, '{9'd1, 23'h004000, 4'd0, 1'b0, 1'b0, 1'b0}},
    // Bank zero is mapped up to one.
    '{ROW_BEAT, '0, 15'h2000, 10'h000, 1'b1, '{9'd1, 23'h004000, 4'd0, 1'b0, 1'b0, 1'b0}},
    // Top of the mode region, all data bits set: RAM banking mode.
    '{ROW_BEAT, '0, 15'h7FFF, 10'h0FF, 1'b1, '{9'd1, 23'h004000, 4'd0, 1'b0, 1'b0, 1'b1}},
    // MBC1 at the largest bank counts.
    '{ROW_REG, CfgRamBankCnt, '0, 10'd16, 1'b0, '0},
    '{ROW_REG, CfgRomBankCnt, '0, 10'd512, 1'b0, '0},
    '{ROW_BEAT, '0, 15'h1FFF, 10'h0FA, 1'b0, '0},
    '{ROW_BEAT, '0, 15'h2000, 10'h01F, 1'b0, '0},
    '{ROW_BEAT, '0, 15'h6000, 10'h000, 1'b0, '0},
    '{ROW_BEAT, '0, 15'h4000, 10'h003, 1'b0, '0},
    // Low bits cleared with high bits three: bank 0x60 becomes 0x61.
    '{ROW_BEAT, '0, 15'h2000, 10'h020, 1'b0, '0},
    '{ROW_BEAT, '0, 15'h6000, 10'h001, 1'b0, '0},
    '{ROW_BEAT, '0, 15'h5FFF, 10'h0FF, 1'b0, '0},
    '{ROW_BEAT, '0, 15'h0000, 10'h000, 1'b0, '0},
    // MBC2 with a single RAM bank.
    '{ROW_REG, CfgCtrlType, '0, 10'(CT_MBC2), 1'b0, '0},
    '{ROW_REG, CfgRomBankCnt, '0, 10'd16, 1'b0, '0},
    '{ROW_REG, CfgRamBankCnt, '0, 10'd1, 1'b0, '0},
    // Address bit four set: MBC2 ignores the RAM enable write.
    '{ROW_BEAT, '0, 15'h0010, 10'h00A, 1'b0, '0},
    '{ROW_BEAT, '0, 15'h0000, 10'h00A, 1'b0, '0},
    '{ROW_BEAT, '0, 15'h2100, 10'h000, 1'b0, '0},
    '{ROW_BEAT, '0, 15'h3FFF, 10'h0FF, 1'b0, '0},
    '{ROW_BEAT, '0, 15'h4000, 10'h003, 1'b0, '0},
    // MBC3 with a bank count that forces wrapping.
    '{ROW_REG, CfgCtrlType, '0, 10'(CT_MBC3), 1'b0, '0},
    '{ROW_REG, CfgRomBankCnt, '0, 10'd5, 1'b0, '0},
    '{ROW_REG, CfgRamBankCnt, '0, 10'd4, 1'b0, '0},
    '{ROW_BEAT, '0, 15'h2000, 10'h07F, 1'b0, '0},
    // Wraps to zero, which MBC3 turns into one.
    '{ROW_BEAT, '0, 15'h2000, 10'h005, 1'b0, '0},
    '{ROW_BEAT, '0, 15'h4000, 10'h008, 1'b0, '0},
    '{ROW_BEAT, '0, 15'h4000, 10'h003, 1'b0, '0},
    '{ROW_BEAT, '0, 15'h6000, 10'h001, 1'b0, '0},
    // MBC5 with zero ROM and RAM counts: every bank reads as zero.
    '{ROW_REG, CfgCtrlType, '0, 10'(CT_MBC5), 1'b0, '0},
    '{ROW_REG, CfgRomBankCnt, '0, 10'd0, 1'b0, '0},
    '{ROW_REG, CfgRamBankCnt, '0, 10'd0, 1'b0, '0},
    '{ROW_BEAT, '0, 15'h2000, 10'h0FF, 1'b0, '0},
    '{ROW_REG, CfgRomBankCnt, '0, 10'd300, 1'b0, '0},
    // Bank bit eight from 0x3000 up, then the low byte below it.
    '{ROW_BEAT, '0, 15'h3000, 10'h001, 1'b0, '0},
    '{ROW_BEAT, '0, 15'h2FFF, 10'h0FF, 1'b0, '0},
    '{ROW_BEAT, '0, 15'h4000, 10'h0FF, 1'b0, '0},
    // A write to the unused register index changes nothing.
    '{ROW_REG, CfgUnused, '0, 10'h3FF, 1'b0, '0}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;

  // Set for the closing phase, where neither side idles.
  logic        no_idle;
  int unsigned mismatch_cnt;
  int unsigned quiet_cycles;

  // Bank states still owed by the block, oldest first.
  out_t        bank_state_q[$];

  // Predictor copy of the configuration and of the bank registers.
  ctrl_type_e  mbc_type  = CT_MBC1;
  logic [9:0]  rom_count = 10'd2;
  logic [4:0]  ram_count = 5'd0;
  logic [8:0]  rom_sel   = 9'd1;
  logic [3:0]  ram_sel   = 4'd0;
  logic        rtc_sel   = 1'b0;
  logic        ram_on    = 1'b0;
  logic        ram_mode  = 1'b0;

  cartridge_bank_controller dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A bank number at or above the ROM count wraps modulo the count; no banks means bank 0.
  function automatic logic [8:0] fold_rom(int unsigned v);
    v = v & 'h1FF;
    if (rom_count == 0) return '0;
    if (v >= rom_count) v = v % rom_count;
    return v[8:0];
  endfunction

  function automatic logic [3:0] fold_ram(int unsigned v);
    if (ram_count == 0) return '0;
    if (v >= ram_count) v = v % ram_count;
    return v[3:0];
  endfunction

  // MBC1 cannot select banks 0x00, 0x20, 0x40 or 0x60 and lands one bank higher.
  function automatic int unsigned skip_hole(int unsigned v);
    return (v == 'h00 || v == 'h20 || v == 'h40 || v == 'h60) ? v + 1 : v;
  endfunction

  // Applies one CPU write to the predicted bank registers and returns the resulting state.
  function automatic out_t next_bank_state(in_t w);
    int unsigned d;
    int unsigned v;
    out_t s;
    d = w.write_data;
    case (w.write_address[14:13])
      RegionRamEn: begin
        if (!(mbc_type == CT_MBC2 && w.write_address[4]) && ram_count != 0)
          ram_on = (w.write_data[3:0] == RamEnKey);
      end
      RegionRomBank: begin
        case (mbc_type)
          CT_MBC1: rom_sel = fold_rom(skip_hole((rom_sel & 'hE0) | (d & 'h1F)));
          CT_MBC2: begin
            v = d & 'hF;
            if (v == 0) v = 1;
            rom_sel = fold_rom(v);
          end
          CT_MBC3: begin
            v = fold_rom(d & 127);
            if (v == 0 && rom_count != 0) v = 1;
            rom_sel = v[8:0];
          end
          default: begin
            // MBC5 splits the region: low byte below 0x3000, bit eight from 0x3000 up.
            if (w.write_address < 15'h3000) rom_sel = fold_rom((rom_sel & 'h100) | d);
            else rom_sel = fold_rom((rom_sel & 'hFF) | ((d & 1) << 8));
          end
        endcase
      end
      RegionRamBank: begin
        case (mbc_type)
          CT_MBC1: begin
            if (!ram_mode) rom_sel = fold_rom(skip_hole((rom_sel & 'h1F) | ((d & 3) << 5)));
            else if (ram_count <= 1) ram_sel = '0;
            else ram_sel = fold_ram(d & 3);
          end
          CT_MBC3: begin
            // Values above three pick a clock register and leave the RAM bank alone.
            if (d > 3) begin
              rtc_sel = 1'b1;
            end else begin
              rtc_sel = 1'b0;
              ram_sel = fold_ram(d);
            end
          end
          CT_MBC5: ram_sel = fold_ram(d & 'hF);
          default: ;
        endcase
      end
      default: begin
        if (mbc_type == CT_MBC1) begin
          ram_mode = w.write_data[0];
          if (!ram_mode) ram_sel = '0;
        end
      end
    endcase
    s.rom_bank         = rom_sel;
    s.rom_base_offset  = 23'(rom_sel) << BankShift;
    s.ram_bank         = ram_sel;
    s.rtc_selected     = rtc_sel;
    s.ram_enabled      = ram_on;
    s.ram_banking_mode = ram_mode;
    return s;
  endfunction

  // Drives one CPU write beat from a falling edge and records the state it must produce.
  // Returns at the falling edge after the beat was taken, with valid low.
  task automatic send_write(input in_t w, input logic typed, input out_t typed_state);
    out_t predicted;
    if (!no_idle && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 13)) @(negedge clk);
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (!in_ready);
    // The predictor always advances; a typed row only replaces what is compared.
    predicted = next_bank_state(w);
    bank_state_q.push_back(typed ? typed_state : predicted);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Writes one register once every owed result has come back and the block has gone quiet.
  task automatic write_reg(input logic [1:0] idx, input logic [9:0] value);
    while (bank_state_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CfgCtrlType:   mbc_type = ctrl_type_e'(value[1:0]);
      CfgRomBankCnt: rom_count = value;
      CfgRamBankCnt: ram_count = value[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result side: stalls come in random bursts, and stop in the closing phase.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && !no_idle && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_ready = rst_n;
      end
    end
  end

  // Every accepted result beat is compared with the oldest owed bank state.
  always @(posedge clk) begin : check_result
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (bank_state_q.size() == 0) begin
        $error("result beat arrived with no write outstanding");
        mismatch_cnt++;
      end else begin
        want = bank_state_q.pop_front();
        if (out_data.rom_bank !== want.rom_bank) begin
          $error("rom_bank: expected %0d, got %0d", want.rom_bank, out_data.rom_bank);
          mismatch_cnt++;
        end
        if (out_data.rom_base_offset !== want.rom_base_offset) begin
          $error("rom_base_offset: expected 0x%0h, got 0x%0h",
                 want.rom_base_offset, out_data.rom_base_offset);
          mismatch_cnt++;
        end
        if (out_data.ram_bank !== want.ram_bank) begin
          $error("ram_bank: expected %0d, got %0d", want.ram_bank, out_data.ram_bank);
          mismatch_cnt++;
        end
        if (out_data.rtc_selected !== want.rtc_selected) begin
          $error("rtc_selected: expected %0b, got %0b", want.rtc_selected, out_data.rtc_selected);
          mismatch_cnt++;
        end
        if (out_data.ram_enabled !== want.ram_enabled) begin
          $error("ram_enabled: expected %0b, got %0b", want.ram_enabled, out_data.ram_enabled);
          mismatch_cnt++;
        end
        if (out_data.ram_banking_mode !== want.ram_banking_mode) begin
          $error("ram_banking_mode: expected %0b, got %0b",
                 want.ram_banking_mode, out_data.ram_banking_mode);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: a long stretch with no beat on any channel means the block has hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IdleLimit) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    row_t        r;
    in_t         w;
    logic [9:0]  rom_pick;
    logic [9:0]  ram_pick;
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_data      = '0;
    no_idle      = 1'b0;
    mismatch_cnt = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: walk the table, typed expectations where given.
    for (int i = 0; i < NumRows; i++) begin
      r = PLAN[i];
      if (r.kind == ROW_REG) begin
        write_reg(r.reg_idx, r.data);
      end else begin
        w.write_address = r.addr;
        w.write_data    = r.data[7:0];
        send_write(w, r.typed, r.state);
      end
    end

    // Random part: a fresh configuration per phase, then random writes under it.
    for (int ph = 0; ph < RandPhases; ph++) begin
      if (ph == RandPhases - 1) no_idle = 1'b1;
      case ($urandom_range(0, 5))
        0:       rom_pick = 10'd0;
        1:       rom_pick = 10'd2;
        2:       rom_pick = 10'd512;
        3:       rom_pick = 10'd1 << $urandom_range(1, 9);
        default: rom_pick = 10'($urandom_range(2, 512));
      endcase
      case ($urandom_range(0, 4))
        0:       ram_pick = 10'd0;
        1:       ram_pick = 10'd1;
        2:       ram_pick = 10'd16;
        default: ram_pick = 10'($urandom_range(0, 16));
      endcase
      write_reg(CfgCtrlType, 10'($urandom_range(0, 3)));
      write_reg(CfgRomBankCnt, rom_pick);
      write_reg(CfgRamBankCnt, ram_pick);
      if ($urandom_range(0, 3) == 0) write_reg(CfgUnused, 10'($urandom));
      repeat (BeatsPerPhase) begin
        w.write_address = 15'($urandom);
        w.write_data    = 8'($urandom);
        // Bias the data toward the enable key, the MBC1 holes and the small bank values.
        case ($urandom_range(0, 5))
          0:       w.write_data[3:0] = RamEnKey;
          1:       w.write_data[4:0] = '0;
          2:       w.write_data = 8'($urandom_range(0, 7));
          default: ;
        endcase
        send_write(w, 1'b0, '0);
      end
    end

    while (bank_state_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
